/* sv/clt_pkg.sv */
package clt_pkg;

    localparam int ENTRIES  = 16;
    localparam int HANDLE_W = $clog2(ENTRIES);
    localparam int COUNT_W  = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_INSERT    = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_SETLISTEN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE        = 2'd0,
        KIND_EXACT       = 2'd1,
        KIND_LISTEN_ADDR = 2'd2,
        KIND_LISTEN_ANY  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [15:0] lport;
        logic [31:0] remote_addr;
        logic [15:0] rport;
    } key_t;

    typedef struct packed {
        key_t key;
        logic listening;
    } entry_t;

    typedef struct packed {
        logic exact;
        logic listen_addr;
        logic listen_any;
    } match_t;

endpackage

/* sv/clt_ram.sv */
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/clt_match.sv */
module clt_match (
    input  clt_pkg::entry_t entry,
    input  clt_pkg::key_t   key,
    output clt_pkg::match_t hit
);

    logic port_hit;

    assign hit.exact = (entry.key.local_addr == key.local_addr)
                    && (entry.key.lport == key.lport)
                    && (entry.key.remote_addr == key.remote_addr)
                    && (entry.key.rport == key.rport);

    // listening entries match on the local side only
    assign port_hit       = entry.listening && (entry.key.lport == key.lport);
    assign hit.listen_addr = port_hit && (entry.key.local_addr == key.local_addr);
    assign hit.listen_any  = port_hit && (entry.key.local_addr == 32'd0);

endmodule

/* sv/connection_tuple_lookup_table.sv */
// Connection table for segment demultiplexing.
//
// Request channel: drive op and the tuple fields with start high; the request
// is taken at the clock edge where start is high and busy is low. busy stays
// high until the cycle that carries the result.
// Result channel: done is high for exactly one cycle with status, handle_out
// and match_kind valid. The receiver cannot hold a result off.
//
// Insert, a full table, a bad handle for remove or set listen, and lookup on an
// empty table are answered straight from the idle state. Set listen reads the
// entry, then writes it back with the new flag. Remove compacts the search order,
// one entry a cycle; lookup walks the search order, one entry a cycle. The order
// memory feeds the entry memory, each with one registered read port; an exact or
// same-address hit ends the lookup walk early. A new request may be taken in the
// done cycle.
//
// Reset clears the valid bits and the entry count; the memories keep their
// contents and need no clearing pass, since only the contents of valid slots are ever used.
module connection_tuple_lookup_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] local_addr,
    input  logic [15:0] local_port_num,
    input  logic [31:0] remote_addr,
    input  logic [15:0] remote_port_num,
    input  logic        listen_flag,
    input  logic [3:0]  handle_in,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  handle_out,
    output logic [1:0]  match_kind
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LK_WALK,
        S_RM_WALK,
        S_SL_WR
    } state_t;

    localparam int HW = clt_pkg::HANDLE_W;
    localparam int CW = clt_pkg::COUNT_W;

    state_t                    state_reg, state_next;
    logic [clt_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]             count_reg, count_next;
    clt_pkg::key_t             key_reg, key_next;
    logic                      lf_reg, lf_next;
    logic [HW-1:0]             h_reg, h_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [CW-1:0]             wr_idx_reg, wr_idx_next;
    logic                      p1_vld_reg, p1_vld_next;
    logic                      p2_vld_reg, p2_vld_next;
    logic [HW-1:0]             slot_p2_reg, slot_p2_next;
    logic                      any_vld_reg, any_vld_next;
    logic [HW-1:0]             any_slot_reg, any_slot_next;
    logic                      done_reg, done_next;
    clt_pkg::status_t          status_reg, status_next;
    logic [HW-1:0]             handle_reg, handle_next;
    clt_pkg::kind_t            kind_reg, kind_next;
    logic                      busy_reg, busy_next;

    // memory ports
    logic            ent_we;
    logic [HW-1:0]   ent_waddr;
    clt_pkg::entry_t ent_wdata;
    logic [HW-1:0]   ent_raddr;
    clt_pkg::entry_t ent_q;
    logic            ord_we;
    logic [HW-1:0]   ord_waddr;
    logic [HW-1:0]   ord_wdata;
    logic [HW-1:0]   ord_raddr;
    logic [HW-1:0]   ord_q;

    clt_pkg::key_t   req_key;
    clt_pkg::match_t hit;
    logic            free_found;
    logic [HW-1:0]   free_slot;

    logic              fin;
    clt_pkg::status_t  fin_status;
    logic [HW-1:0]     fin_handle;
    clt_pkg::kind_t    fin_kind;

    assign req_key.local_addr  = local_addr;
    assign req_key.lport       = local_port_num;
    assign req_key.remote_addr = remote_addr;
    assign req_key.rport       = remote_port_num;

    // slot fields, tuple and listen flag
    clt_ram #(
        .WIDTH ($bits(clt_pkg::entry_t)),
        .DEPTH (clt_pkg::ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_q)
    );

    // search order, oldest first
    clt_ram #(
        .WIDTH (HW),
        .DEPTH (clt_pkg::ENTRIES)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    clt_match u_match (
        .entry (ent_q),
        .key   (key_reg),
        .hit   (hit)
    );

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = clt_pkg::ENTRIES - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = HW'(s);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        lf_next       = lf_reg;
        h_next        = h_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        p1_vld_next   = 1'b0;
        p2_vld_next   = 1'b0;
        slot_p2_next  = slot_p2_reg;
        any_vld_next  = any_vld_reg;
        any_slot_next = any_slot_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        handle_next   = handle_reg;
        kind_next     = kind_reg;

        ent_we     = 1'b0;
        ent_waddr  = h_reg;
        ent_wdata  = ent_q;
        // entry read: request handle while idle, order data during the walk
        ent_raddr  = (state_reg == S_IDLE) ? handle_in : ord_q;
        ord_we     = 1'b0;
        ord_waddr  = wr_idx_reg[HW-1:0];
        ord_wdata  = ord_q;
        ord_raddr  = rd_idx_reg[HW-1:0];

        fin        = 1'b0;
        fin_status = clt_pkg::ST_OK;
        fin_handle = '0;
        fin_kind   = clt_pkg::KIND_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next     = req_key;
                    lf_next      = listen_flag;
                    h_next       = handle_in;
                    rd_idx_next  = '0;
                    wr_idx_next  = '0;
                    any_vld_next = 1'b0;
                    unique case (clt_pkg::op_t'(op))
                        clt_pkg::OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = clt_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_LK_WALK;
                            end
                        end
                        clt_pkg::OP_INSERT:
                        begin
                            fin = 1'b1;
                            if (!free_found)
                            begin
                                fin_status = clt_pkg::ST_FULL;
                            end
                            else
                            begin
                                // store the tuple and append the slot to the order
                                ent_we                = 1'b1;
                                ent_waddr             = free_slot;
                                ent_wdata.key         = req_key;
                                ent_wdata.listening   = listen_flag;
                                ord_we                = 1'b1;
                                ord_waddr             = count_reg[HW-1:0];
                                ord_wdata             = free_slot;
                                valid_next[free_slot] = 1'b1;
                                count_next            = count_reg + CW'(1);
                                fin_handle            = free_slot;
                            end
                        end
                        clt_pkg::OP_REMOVE:
                        begin
                            if (!valid_reg[handle_in])
                            begin
                                fin        = 1'b1;
                                fin_status = clt_pkg::ST_BAD_HANDLE;
                            end
                            else
                            begin
                                valid_next[handle_in] = 1'b0;
                                state_next            = S_RM_WALK;
                            end
                        end
                        clt_pkg::OP_SETLISTEN:
                        begin
                            if (!valid_reg[handle_in])
                            begin
                                fin        = 1'b1;
                                fin_status = clt_pkg::ST_BAD_HANDLE;
                            end
                            else
                            begin
                                state_next = S_SL_WR;
                            end
                        end
                    endcase
                end
            end

            S_LK_WALK:
            begin
                // issue the next order read
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    p1_vld_next = 1'b1;
                end
                // order data addresses the entry memory
                p2_vld_next  = p1_vld_reg;
                slot_p2_next = ord_q;
                // compare the entry against the key
                priority if (p2_vld_reg && valid_reg[slot_p2_reg] && hit.exact)
                begin
                    fin        = 1'b1;
                    fin_handle = slot_p2_reg;
                    fin_kind   = clt_pkg::KIND_EXACT;
                end
                else if (p2_vld_reg && valid_reg[slot_p2_reg] && hit.listen_addr)
                begin
                    fin        = 1'b1;
                    fin_handle = slot_p2_reg;
                    fin_kind   = clt_pkg::KIND_LISTEN_ADDR;
                end
                else if (p2_vld_reg && valid_reg[slot_p2_reg] && hit.listen_any)
                begin
                    // keep the latest wildcard listener, continue the walk
                    any_vld_next  = 1'b1;
                    any_slot_next = slot_p2_reg;
                end
                else if (!p1_vld_reg && !p2_vld_reg && rd_idx_reg >= count_reg)
                begin
                    fin = 1'b1;
                    if (any_vld_reg)
                    begin
                        fin_handle = any_slot_reg;
                        fin_kind   = clt_pkg::KIND_LISTEN_ANY;
                    end
                    else
                    begin
                        fin_status = clt_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    fin = 1'b0;
                end
            end

            S_RM_WALK:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    p1_vld_next = 1'b1;
                end
                // copy every other slot down; writes never pass the read pointer
                if (p1_vld_reg && ord_q != h_reg)
                begin
                    ord_we      = 1'b1;
                    ord_waddr   = wr_idx_reg[HW-1:0];
                    ord_wdata   = ord_q;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if (!p1_vld_reg && rd_idx_reg >= count_reg)
                begin
                    count_next = wr_idx_reg;
                    fin        = 1'b1;
                    fin_handle = h_reg;
                end
            end

            S_SL_WR:
            begin
                // write back the entry with the new listen flag
                ent_we              = 1'b1;
                ent_waddr           = h_reg;
                ent_wdata.key       = ent_q.key;
                ent_wdata.listening = lf_reg;
                fin                 = 1'b1;
                fin_handle          = h_reg;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = fin_status;
            handle_next = fin_handle;
            kind_next   = fin_kind;
        end
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            key_reg      <= '0;
            lf_reg       <= 1'b0;
            h_reg        <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            slot_p2_reg  <= '0;
            any_vld_reg  <= 1'b0;
            any_slot_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= clt_pkg::ST_OK;
            handle_reg   <= '0;
            kind_reg     <= clt_pkg::KIND_NONE;
            busy_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            key_reg      <= key_next;
            lf_reg       <= lf_next;
            h_reg        <= h_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            p1_vld_reg   <= p1_vld_next;
            p2_vld_reg   <= p2_vld_next;
            slot_p2_reg  <= slot_p2_next;
            any_vld_reg  <= any_vld_next;
            any_slot_reg <= any_slot_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            handle_reg   <= handle_next;
            kind_reg     <= kind_next;
            busy_reg     <= busy_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign handle_out = handle_reg;
    assign match_kind = kind_reg;

    // between requests the entry count equals the number of valid slots
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == 32'(count_reg)))
        else $error("entry count out of step with valid slots");

    // a result never arrives while a request is still in work
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // a failed request carries no handle and no match kind
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != clt_pkg::ST_OK) |-> (handle_out == '0 && match_kind == '0))
        else $error("failed result carries handle or kind");

    // only a lookup walk sets a match kind, so no table change goes with one
    a_kind_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done && match_kind != clt_pkg::KIND_NONE) |-> $stable(valid_reg))
        else $error("match reported together with a table change");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    // Allow for 700+ requests, each with a full lookup walk and a long
    // sender gap, several times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HW = clt_pkg::HANDLE_W;

    typedef struct packed {
        clt_pkg::status_t status;
        logic [3:0]       handle;
        clt_pkg::kind_t   kind;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [31:0] local_addr;
    logic [15:0] local_port_num;
    logic [31:0] remote_addr;
    logic [15:0] remote_port_num;
    logic        listen_flag;
    logic [3:0]  handle_in;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  handle_out;
    logic [1:0]  match_kind;

    connection_tuple_lookup_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .local_addr      (local_addr),
        .local_port_num  (local_port_num),
        .remote_addr     (remote_addr),
        .remote_port_num (remote_port_num),
        .listen_flag     (listen_flag),
        .handle_in       (handle_in),
        .done            (done),
        .status          (status),
        .handle_out      (handle_out),
        .match_kind      (match_kind)
    );

    // Shadow copy of the connection table, updated at each accepted request.
    clt_pkg::entry_t       conn_entry [clt_pkg::ENTRIES];
    bit                    conn_used  [clt_pkg::ENTRIES];
    logic [HW-1:0]         conn_order [clt_pkg::ENTRIES];
    int                    conn_count;

    // Replies predicted for accepted requests, oldest first.
    reply_t pending_replies [$];

    int error_count;
    int reply_count;
    int cycle_count;
    int sender_idle_pct;

    // Fixed address and port pools make matches and listeners collide often.
    logic [31:0] addr_pool [4] = '{32'h0000_0000, 32'h0A00_0001, 32'hC0A8_0101,
                                   32'hFFFF_FFFF};
    logic [15:0] port_pool [4] = '{16'd0, 16'd80, 16'd443, 16'hFFFF};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Reply prediction
    // ------------------------------------------------------------------
    function automatic reply_t mk_reply(clt_pkg::status_t st, logic [3:0] h,
                                        clt_pkg::kind_t k);
        reply_t r;
        r.status = st;
        r.handle = h;
        r.kind   = k;
        return r;
    endfunction

    // Compute the reply for one request and advance the shadow table.
    function automatic reply_t predict_reply(clt_pkg::op_t o, clt_pkg::key_t k,
                                             logic lf, logic [3:0] h);
        bit            have_any;
        logic [HW-1:0] any_slot;
        logic [HW-1:0] s;
        int            free_slot;
        int            j;
        have_any  = 1'b0;
        any_slot  = '0;
        free_slot = -1;
        j         = 0;
        case (o)
            clt_pkg::OP_LOOKUP:
            begin
                // Walk oldest to newest; exact or same-address listener wins at
                // once, the newest wildcard listener is the fallback.
                for (int i = 0; i < conn_count; i++)
                begin
                    s = conn_order[i];
                    if (!conn_used[s])
                        continue;
                    if (conn_entry[s].key == k)
                        return mk_reply(clt_pkg::ST_OK, s, clt_pkg::KIND_EXACT);
                    if (conn_entry[s].listening &&
                        conn_entry[s].key.lport == k.lport)
                    begin
                        if (conn_entry[s].key.local_addr == k.local_addr)
                            return mk_reply(clt_pkg::ST_OK, s, clt_pkg::KIND_LISTEN_ADDR);
                        if (conn_entry[s].key.local_addr == 32'd0)
                        begin
                            have_any = 1'b1;
                            any_slot = s;
                        end
                    end
                end
                if (have_any)
                    return mk_reply(clt_pkg::ST_OK, any_slot, clt_pkg::KIND_LISTEN_ANY);
                return mk_reply(clt_pkg::ST_NOT_FOUND, 4'd0, clt_pkg::KIND_NONE);
            end
            clt_pkg::OP_INSERT:
            begin
                for (int i = clt_pkg::ENTRIES - 1; i >= 0; i--)
                    if (!conn_used[i])
                        free_slot = i;
                if (free_slot < 0 || conn_count >= clt_pkg::ENTRIES)
                    return mk_reply(clt_pkg::ST_FULL, 4'd0, clt_pkg::KIND_NONE);
                conn_used[free_slot]            = 1'b1;
                conn_entry[free_slot].key       = k;
                conn_entry[free_slot].listening = lf;
                conn_order[conn_count]          = HW'(free_slot);
                conn_count++;
                return mk_reply(clt_pkg::ST_OK, 4'(free_slot), clt_pkg::KIND_NONE);
            end
            clt_pkg::OP_REMOVE:
            begin
                if (h >= clt_pkg::ENTRIES || !conn_used[h])
                    return mk_reply(clt_pkg::ST_BAD_HANDLE, 4'd0, clt_pkg::KIND_NONE);
                conn_used[h] = 1'b0;
                // Close the gap, keep the relative order of the rest.
                for (int i = 0; i < conn_count; i++)
                begin
                    if (conn_order[i] != h)
                    begin
                        conn_order[j] = conn_order[i];
                        j++;
                    end
                end
                conn_count = j;
                return mk_reply(clt_pkg::ST_OK, h, clt_pkg::KIND_NONE);
            end
            default:
            begin
                if (h >= clt_pkg::ENTRIES || !conn_used[h])
                    return mk_reply(clt_pkg::ST_BAD_HANDLE, 4'd0, clt_pkg::KIND_NONE);
                conn_entry[h].listening = lf;
                return mk_reply(clt_pkg::ST_OK, h, clt_pkg::KIND_NONE);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Drive one request at the falling edge, hold it until the rising edge
    // where busy is low, then record its predicted reply.
    task automatic send_request(clt_pkg::op_t o, clt_pkg::key_t k, logic lf,
                                logic [3:0] h);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start           = 1'b1;
        op              = o;
        local_addr      = k.local_addr;
        local_port_num  = k.lport;
        remote_addr     = k.remote_addr;
        remote_port_num = k.rport;
        listen_flag     = lf;
        handle_in       = h;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_replies.push_back(predict_reply(o, k, lf, h));
    endtask

    // Drop start and hold off until every predicted reply has come back.
    task automatic wait_all_replies();
        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Reply checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH reply %0d %s: got %0d expected %0d",
                 reply_count, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("unexpected reply, status", int'(status), 0);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (handle_out !== want.handle)
                    report_mismatch("handle_out", int'(handle_out), int'(want.handle));
                if (match_kind !== want.kind)
                    report_mismatch("match_kind", int'(match_kind), int'(want.kind));
            end
            reply_count++;
        end
    end

    // Watchdog: end the run if the block stops answering.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("connection_tuple_lookup_table verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic clt_pkg::key_t tuple(logic [31:0] la, logic [15:0] lp,
                                            logic [31:0] ra, logic [15:0] rp);
        clt_pkg::key_t k;
        k.local_addr  = la;
        k.lport       = lp;
        k.remote_addr = ra;
        k.rport       = rp;
        return k;
    endfunction

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(3) == 0)
            return $urandom();
        return addr_pool[$urandom_range(3)];
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(65535));
        return port_pool[$urandom_range(3)];
    endfunction

    function automatic clt_pkg::key_t pick_key();
        return tuple(pick_addr(), pick_port(), pick_addr(), pick_port());
    endfunction

    // Mostly a live slot, now and then any handle so free slots get hit.
    function automatic logic [3:0] pick_handle();
        logic [3:0] h;
        h = 4'($urandom_range(15));
        if (conn_count == 0 || $urandom_range(4) == 0)
            return h;
        return conn_order[$urandom_range(conn_count - 1)];
    endfunction

    // Lookup key built from a live entry so that every match kind occurs.
    function automatic clt_pkg::key_t pick_lookup_key();
        clt_pkg::key_t k;
        if (conn_count == 0)
            return pick_key();
        k = conn_entry[conn_order[$urandom_range(conn_count - 1)]].key;
        case ($urandom_range(4))
            0: ;                                        // exact tuple
            1:
            begin
                k.remote_addr = pick_addr();            // same local side
                k.rport       = pick_port();
            end
            2:
            begin
                k.local_addr  = pick_addr();            // wildcard candidates
                k.remote_addr = $urandom();
            end
            3: k = pick_key();
            default: k = tuple($urandom(), 16'($urandom_range(65535)),
                               $urandom(), 16'($urandom_range(65535)));
        endcase
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty table: lookup misses, remove and set listen hit free slots.
    task automatic test_empty_table();
        send_request(clt_pkg::OP_LOOKUP, tuple('0, '0, '0, '0), 1'b0, 4'd0);
        send_request(clt_pkg::OP_REMOVE, tuple('1, '1, '1, '1), 1'b1, 4'd0);
        send_request(clt_pkg::OP_SETLISTEN, tuple('0, '0, '0, '0), 1'b1, 4'd15);
    endtask

    // Exact, same-address listener, newest wildcard, duplicate, and misses.
    task automatic test_match_kinds();
        // slot 0
        send_request(clt_pkg::OP_INSERT, tuple('1, '1, '1, '1), 1'b0, 4'd9);
        // slot 1
        send_request(clt_pkg::OP_INSERT, tuple(32'd0, 16'd80, '0, '0), 1'b1, 4'd0);
        // slot 2
        send_request(clt_pkg::OP_INSERT, tuple(32'd0, 16'd80, '1, 16'd7), 1'b1, 4'd0);
        // slot 3
        send_request(clt_pkg::OP_INSERT, tuple(32'h0A00_0001, 16'd80, 32'h1, 16'd1),
                     1'b1, 4'd0);
        // duplicate, slot 4
        send_request(clt_pkg::OP_INSERT, tuple('1, '1, '1, '1), 1'b1, 4'd0);
        send_request(clt_pkg::OP_LOOKUP, tuple('1, '1, '1, '1), 1'b0, 4'd0);
        send_request(clt_pkg::OP_LOOKUP, tuple(32'hC0A8_0101, 16'd80, 32'h5, 16'd9),
                     1'b0, 4'd0);
        send_request(clt_pkg::OP_LOOKUP, tuple(32'h0A00_0001, 16'd80, 32'h5, 16'd9),
                     1'b0, 4'd0);
        send_request(clt_pkg::OP_LOOKUP, tuple('0, '0, '0, '0), 1'b1, 4'd15);
        send_request(clt_pkg::OP_LOOKUP, tuple('1, 16'd80, '0, '0), 1'b0, 4'd0);
    endtask

    // Remove closes the gap, set listen retargets the wildcard fallback.
    task automatic test_remove_and_relisten();
        send_request(clt_pkg::OP_REMOVE, pick_key(), 1'b0, 4'd0);
        send_request(clt_pkg::OP_LOOKUP, tuple('1, '1, '1, '1), 1'b0, 4'd0);
        send_request(clt_pkg::OP_SETLISTEN, pick_key(), 1'b0, 4'd2);
        send_request(clt_pkg::OP_LOOKUP, tuple(32'hC0A8_0101, 16'd80, 32'h5, 16'd9),
                     1'b0, 4'd0);
        send_request(clt_pkg::OP_REMOVE, pick_key(), 1'b1, 4'd1);
        send_request(clt_pkg::OP_LOOKUP, tuple(32'hC0A8_0101, 16'd80, 32'h5, 16'd9),
                     1'b0, 4'd0);
        // lowest free
        send_request(clt_pkg::OP_INSERT, tuple(32'd0, '1, '0, '1), 1'b1, 4'd0);
    endtask

    // Fill every slot, then one more insert reports full.
    task automatic test_full_table();
        while (conn_count < clt_pkg::ENTRIES)
            send_request(clt_pkg::OP_INSERT, pick_key(), 1'($urandom_range(1)),
                         4'($urandom_range(15)));
        send_request(clt_pkg::OP_INSERT, pick_key(), 1'b1, 4'd0);
        send_request(clt_pkg::OP_LOOKUP,
                     conn_entry[conn_order[clt_pkg::ENTRIES - 1]].key, 1'b0, 4'd0);
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct);
        int            pick;
        int            ins_w;
        int            rem_w;
        clt_pkg::op_t  o;
        clt_pkg::key_t k;
        for (int i = 0; i < n_items; i++)
        begin
            // Break the idle pattern with short back-to-back bursts.
            sender_idle_pct = ((i % 60) < 10) ? 0 : idle_pct;
            // Lean toward removes when nearly full so the table keeps churning.
            ins_w = (conn_count > 12) ? 20 : 30;
            rem_w = (conn_count > 12) ? 25 : 12;
            pick  = $urandom_range(99);
            if (pick < 40)
                o = clt_pkg::OP_LOOKUP;
            else if (pick < 40 + ins_w)
                o = clt_pkg::OP_INSERT;
            else if (pick < 40 + ins_w + rem_w)
                o = clt_pkg::OP_REMOVE;
            else
                o = clt_pkg::OP_SETLISTEN;
            k = (o == clt_pkg::OP_LOOKUP) ? pick_lookup_key() : pick_key();
            send_request(o, k, 1'($urandom_range(1)),
                         (o == clt_pkg::OP_REMOVE || o == clt_pkg::OP_SETLISTEN)
                             ? pick_handle() : 4'($urandom_range(15)));
            if ($urandom_range(99) < 2)
                wait_all_replies();
        end
        wait_all_replies();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = clt_pkg::OP_LOOKUP;
        local_addr      = '0;
        local_port_num  = '0;
        remote_addr     = '0;
        remote_port_num = '0;
        listen_flag     = 1'b0;
        handle_in       = '0;
        error_count     = 0;
        reply_count     = 0;
        sender_idle_pct = 0;
        conn_count      = 0;
        for (int i = 0; i < clt_pkg::ENTRIES; i++)
        begin
            conn_used[i]  = 1'b0;
            conn_entry[i] = '0;
            conn_order[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_match_kinds();
        test_remove_and_relisten();
        test_full_table();
        wait_all_replies();

        test_random_traffic(240, 0);
        test_random_traffic(230, 84);
        test_random_traffic(230, 17);

        wait_all_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("connection_tuple_lookup_table verification clean");
        else
            $display("connection_tuple_lookup_table verification failed");
        $finish;
    end

endmodule
